FILE: hdl/ccov_pkg.sv
// Shared constants for the CIGAR coverage accumulator.
package ccov_pkg;

    // Default number of window counters.
    localparam int WINDOW_LEN_DEF = 4096;

    // Alignment operation word layout.
    localparam logic [3:0] OP_CODE_MASK = 4'hF;
    localparam int         OP_LEN_SHIFT = 4;
    localparam logic [3:0] OP_MATCH     = 4'd0;

    // Counter saturation value.
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Request kinds carried in tuser.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_OP    = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_START  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_END    = 2'd1;
    localparam logic [1:0] CFG_STRAND_SELECT = 2'd2;

    // Field widths.
    localparam int POS_W    = 31;
    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 32;
    localparam int CUR_W    = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 32;

endpackage

FILE: hdl/cigar_coverage_accumulator.sv
// Coverage pileup over a genomic window, built from a stream of CIGAR operation words.
//
// The block keeps WINDOW_LEN 32-bit saturating counters, one per position of the
// window [window_start, min(window_end, window_start + WINDOW_LEN - 1)], in a
// single-port-write, single-port-read memory. Each input word carries a request kind
// in s_tuser: clear, alignment operation, or read-back. A match operation walks the
// covered positions through one shared increment path: the memory is read at the next
// position while the incremented value of the previous one is written back, so one
// base is counted per cycle. A match word passes the sequencer states CALC1, CALC2 and
// CALC3, then counts its bases inside the window in ACC; any other operation word (or
// a word outside the window) goes back to idle from CALC2 or CALC3, and a word of the
// other strand or an unknown request is dropped in idle. A read-back passes RD1, then
// waits in RD2 until the output slot frees; a clear zeroes every entry in CLR. After
// reset the block clears the memory before its first word; configuration writes are taken
// at any time. s_tready is high only while the sequencer is idle. The result word
// sits in an output register, so a pending result does not stop the next input word;
// only a read-back that finds the slot still full waits for it, holding off the word
// after it. A clear leaves the cursor as it is.
module cigar_coverage_accumulator
    import ccov_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: read_strand[0], first_op[1], read_pos[32:2],
    // cigar_word[64:33], read_offset[76:65], zero pad [79:77]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: coverage_count[31:0]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [POS_W-1:0]      cfg_data
);

    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_CALC1 = 3'd2;
    localparam logic [2:0] S_CALC2 = 3'd3;
    localparam logic [2:0] S_CALC3 = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_RD1   = 3'd6;
    localparam logic [2:0] S_RD2   = 3'd7;

    // Input fields
    logic                in_strand;
    logic                in_first;
    logic [POS_W-1:0]    in_pos;
    logic [WORD_W-1:0]   in_word;
    logic [OFFSET_W-1:0] in_offset;
    logic [31:0]         in_offset_ext;

    assign in_strand     = s_tdata[0];
    assign in_first      = s_tdata[1];
    assign in_pos        = s_tdata[32:2];
    assign in_word       = s_tdata[64:33];
    assign in_offset     = s_tdata[76:65];
    assign in_offset_ext = 32'(in_offset);

    // Configuration
    logic [POS_W-1:0] win_start_reg;
    logic [POS_W-1:0] win_end_reg;
    logic             strand_sel_reg;

    // Control and datapath
    logic [2:0]          state_reg, state_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic                oob_reg, oob_next;
    logic [CUR_W-1:0]    end_reg, end_next;       // effective window end
    logic [CUR_W:0]      op_end_reg, op_end_next; // cursor + length, one carry bit
    logic [CUR_W-1:0]    lo_reg, lo_next;
    logic [CUR_W-1:0]    hi_reg, hi_next;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_data_reg, out_data_next;

    // Memory
    logic [COUNT_W-1:0] mem [WINDOW_LEN];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [COUNT_W-1:0] mem_wd;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;
    logic [COUNT_W-1:0] rd_data_reg;

    // Scratch values
    logic [CUR_W-1:0] ws_ext;
    logic [CUR_W-1:0] lim;
    logic [CUR_W:0]   end_p1;
    logic [CUR_W:0]   hi_w;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ws_ext = CUR_W'(win_start_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg  <= '0;
            win_end_reg    <= POS_W'(4095);
            strand_sel_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WINDOW_START:  win_start_reg  <= cfg_data;
                CFG_WINDOW_END:    win_end_reg    <= cfg_data;
                CFG_STRAND_SELECT: strand_sel_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        wr_idx_next    = wr_idx_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        oob_next       = oob_reg;
        end_next       = end_reg;
        op_end_next    = op_end_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;

        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = idx_reg;

        lim    = ws_ext + CUR_W'(WINDOW_LEN - 1);
        end_p1 = {1'b0, end_reg} + 1'b1;
        hi_w   = (op_end_reg < end_p1) ? op_end_reg : end_p1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    word_next = in_word;
                    case (s_tuser)
                        REQ_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = S_CLR;
                        end
                        REQ_OP:
                        begin
                            if (in_strand == strand_sel_reg)
                            begin
                                if (in_first)
                                    cursor_next = CUR_W'(in_pos);
                                state_next = S_CALC1;
                            end
                        end
                        REQ_READ:
                        begin
                            oob_next   = (in_offset_ext >= 32'(WINDOW_LEN));
                            idx_next   = in_offset_ext[IDX_W-1:0];
                            state_next = S_RD1;
                        end
                        default: ;
                    endcase
                end
            end

            S_CLR:
            begin
                // one entry a cycle
                mem_we   = 1'b1;
                mem_wa   = idx_reg;
                mem_wd   = '0;
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (idx_reg == IDX_W'(WINDOW_LEN - 1))
                    state_next = S_IDLE;
            end

            S_CALC1:
            begin
                end_next    = (CUR_W'(win_end_reg) < lim) ? CUR_W'(win_end_reg) : lim;
                op_end_next = {1'b0, cursor_reg}
                            + (CUR_W + 1)'(word_reg[WORD_W-1:OP_LEN_SHIFT]);
                state_next  = S_CALC2;
            end

            S_CALC2:
            begin
                lo_next = (cursor_reg > ws_ext) ? cursor_reg : ws_ext;
                hi_next = hi_w[CUR_W-1:0];
                if (cursor_reg > end_reg)
                    state_next = S_IDLE;
                else if ((word_reg[3:0] & OP_CODE_MASK) != OP_MATCH
                         || op_end_reg <= {1'b0, ws_ext})
                begin
                    cursor_next = op_end_reg[CUR_W-1:0];
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_CALC3;
            end

            S_CALC3:
            begin
                if (hi_reg > lo_reg)
                begin
                    cursor_next = hi_reg;
                    cnt_next    = CNT_W'(hi_reg - lo_reg);
                    idx_next    = IDX_W'(lo_reg - ws_ext);
                    state_next  = S_ACC;
                end
                else
                begin
                    cursor_next = lo_reg;
                    state_next  = S_IDLE;
                end
            end

            S_ACC:
            begin
                // write back previous position while reading the next
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = wr_idx_reg;
                    mem_wd = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                                        : rd_data_reg + 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    mem_re      = 1'b1;
                    mem_ra      = idx_reg;
                    wr_idx_next = idx_reg;
                    pend_next   = 1'b1;
                    idx_next    = IDX_W'(idx_reg + 1'b1);
                    cnt_next    = CNT_W'(cnt_reg - 1'b1);
                end
                else if (!pend_reg)
                    state_next = S_IDLE;
            end

            S_RD1:
            begin
                mem_re     = 1'b1;
                mem_ra     = idx_reg;
                state_next = S_RD2;
            end

            S_RD2:
            begin
                // read data holds until the output slot frees
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = oob_reg ? '0 : rd_data_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;   // clearing pass after reset
            idx_reg       <= '0;
            cursor_reg    <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cursor_reg    <= cursor_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        wr_idx_reg   <= wr_idx_next;
        oob_reg      <= oob_next;
        end_reg      <= end_next;
        op_end_reg   <= op_end_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
    end

    // Counter memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

endmodule

FILE: bench/cigar_coverage_checker.sv
// Checker for the coverage accumulator: predicts read-back counts and compares result words.
module cigar_coverage_checker
    import ccov_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata, low bit up: read_strand, first_op, read_pos, cigar_word, read_offset, pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: coverage_count
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [POS_W-1:0]      cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [2:0]          pad;
        logic [OFFSET_W-1:0] read_offset;
        logic [WORD_W-1:0]   cigar_word;
        logic [POS_W-1:0]    read_pos;
        logic                first_op;
        logic                read_strand;
    } cov_req_t;

    logic [COUNT_W-1:0] depth_count [WINDOW_LEN];
    logic [CUR_W-1:0]   cursor;
    logic [POS_W-1:0]   win_start;
    logic [POS_W-1:0]   win_end;
    logic               strand_sel;
    logic [COUNT_W-1:0] count_q [$];
    logic [COUNT_W-1:0] want_count;
    cov_req_t           in_word;
    int                 mismatches;
    int                 slot;

    // Last counted position: window end, clipped to the store size.
    function automatic logic [63:0] window_last();
        logic [63:0] cap;
        cap = 64'(win_start) + 64'(WINDOW_LEN) - 64'd1;
        return (64'(win_end) < cap) ? 64'(win_end) : cap;
    endfunction

    // Walk one operation from the cursor; matches bump the counters they overlap.
    task automatic pile_up(input logic [WORD_W-1:0] op);
        logic [63:0] last_pos;
        logic [63:0] cur;
        logic [63:0] ws;
        logic [63:0] op_end;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] p;
        last_pos = window_last();
        cur      = 64'(cursor);
        ws       = 64'(win_start);
        if (cur > last_pos)
            return;
        op_end = cur + 64'(op[WORD_W-1:OP_LEN_SHIFT]);
        if ((op[3:0] & OP_CODE_MASK) != OP_MATCH || op_end <= ws)
        begin
            cursor = op_end[CUR_W-1:0];
            return;
        end
        lo = (cur > ws) ? cur : ws;
        hi = (op_end < last_pos + 64'd1) ? op_end : last_pos + 64'd1;
        for (p = lo; p < hi; p++)
        begin
            if (p - ws < 64'(WINDOW_LEN) && depth_count[p - ws] != COUNT_MAX)
                depth_count[p - ws] = depth_count[p - ws] + 1'b1;
        end
        cursor = (hi > lo) ? hi[CUR_W-1:0] : lo[CUR_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (slot = 0; slot < WINDOW_LEN; slot++)
                depth_count[slot] = '0;
            cursor     = '0;
            win_start  = '0;
            win_end    = POS_W'(4095);
            strand_sel = 1'b0;
            count_q.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_WINDOW_START:  win_start  = cfg_data;
                    CFG_WINDOW_END:    win_end    = cfg_data;
                    CFG_STRAND_SELECT: strand_sel = cfg_data[0];
                    default: ;
                endcase
            end

            // results first, so a word accepted this edge never pairs with itself
            if (m_tvalid && m_tready)
            begin
                if (count_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: coverage_count %0d", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want_count = count_q.pop_front();
                    if (m_tdata[COUNT_W-1:0] !== want_count)
                    begin
                        if (mismatches < 10)
                            $display("coverage_count mismatch: expected %0d, got %0d",
                                     want_count, m_tdata[COUNT_W-1:0]);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                in_word = s_tdata;
                case (s_tuser)
                    REQ_CLEAR:
                    begin
                        for (slot = 0; slot < WINDOW_LEN; slot++)
                            depth_count[slot] = '0;
                    end
                    REQ_OP:
                    begin
                        if (in_word.read_strand == strand_sel)
                        begin
                            if (in_word.first_op)
                                cursor = CUR_W'(in_word.read_pos);
                            pile_up(in_word.cigar_word);
                        end
                    end
                    REQ_READ:
                    begin
                        if (int'(in_word.read_offset) < WINDOW_LEN)
                            count_q.push_back(depth_count[in_word.read_offset]);
                        else
                            count_q.push_back('0);
                    end
                    default: ;
                endcase
            end

            errors  <= mismatches;
            pending <= count_q.size();
        end
    end

endmodule

FILE: bench/cigar_coverage_accumulator_test.sv
// Testbench top for the coverage accumulator: stimulus, flow control and verdict.
module cigar_coverage_accumulator_test;
    import ccov_pkg::*;

    // Request kind the block must drop without a result.
    localparam logic [1:0] REQ_NONE = 2'd3;

    // A few non-match operation codes; all of them only move the cursor.
    localparam logic [3:0] CIGAR_DEL  = 4'd2;
    localparam logic [3:0] CIGAR_SOFT = 4'd4;

    // Longest quiet stretch of a correct run: a full-window match, a clear or the
    // post-reset sweep, the settle pause below, and a receiver held off on top of
    // that. The limit leaves more than twice that.
    localparam int SETTLE_CYCLES   = WINDOW_LEN_DEF + 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata, low bit up: read_strand, first_op, read_pos, cigar_word, read_offset, pad
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // s_tuser: req_type
    logic [1:0]            s_tuser = REQ_CLEAR;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: coverage_count
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = CFG_WINDOW_START;
    logic [POS_W-1:0]      cfg_data = '0;

    int errors;
    int pending;
    int idle_cycles = 0;

    // Flow-control knobs shared by the sender and the receiver.
    logic no_gaps = 1'b0;
    logic hold_off_req = 1'b0;

    // Stimulus copy of the current window, used to aim reads and read-backs.
    logic [POS_W-1:0] ws_now = '0;
    logic             sel_now = 1'b0;
    int               span_now = WINDOW_LEN_DEF;

    always #6 clk = ~clk;

    cigar_coverage_accumulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cigar_coverage_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Watchdog: any accepted word or register write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** cigar_coverage_accumulator: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] op_word(input int len, input logic [3:0] code);
        return {28'(len), code};
    endfunction

    // Result side: random ready with bursts, plus one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        int burst;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                gap = no_gaps ? 0 : pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            burst = $urandom_range(1, 8);
            repeat (burst) @(posedge clk);
        end
    end

    // Offer one word and hold it until the block takes it. Valid stays high on
    // return so a following word can go out back to back.
    task automatic send_word(input logic [1:0] req, input logic strand, input logic first,
                             input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] op,
                             input logic [OFFSET_W-1:0] offset);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, offset, op, pos, first, strand};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_op(input logic strand, input logic first, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] op);
        send_word(REQ_OP, strand, first, pos, op, OFFSET_W'($urandom));
    endtask

    // Fields a read-back or clear does not use carry random values.
    task automatic read_back(input logic [OFFSET_W-1:0] offset);
        send_word(REQ_READ, 1'($urandom), 1'($urandom), POS_W'($urandom), $urandom, offset);
    endtask

    task automatic clear_store();
        send_word(REQ_CLEAR, 1'($urandom), 1'($urandom), POS_W'($urandom), $urandom,
                  OFFSET_W'($urandom));
    endtask

    // Stop sending and wait for every outstanding read-back to come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Op words and clears give no result, so after the drain also let the
    // longest of them finish before touching the registers.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [POS_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_window(input logic [POS_W-1:0] start_pos,
                              input logic [POS_W-1:0] end_pos, input logic strand);
        settle();
        write_reg(CFG_WINDOW_START, start_pos);
        write_reg(CFG_WINDOW_END, end_pos);
        write_reg(CFG_STRAND_SELECT, POS_W'(strand));
        ws_now  = start_pos;
        sel_now = strand;
        if (end_pos < start_pos)
            span_now = 0;
        else if (end_pos - start_pos >= POS_W'(WINDOW_LEN_DEF))
            span_now = WINDOW_LEN_DEF;
        else
            span_now = int'(end_pos - start_pos) + 1;
    endtask

    // Random traffic: mostly reads of 1..6 op words that start near the window,
    // read-backs aimed inside it, plus noise words, rare clears and dropped kinds.
    task automatic feed_reads(input int count);
        int               n;
        int               r;
        int               ops_left;
        logic             strand;
        logic             first;
        logic [POS_W-1:0] pos;
        logic [27:0]      len;
        logic [3:0]       code;
        logic [OFFSET_W-1:0] offset;
        ops_left = 0;
        strand   = sel_now;
        pos      = '0;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (span_now > 0 && $urandom_range(0, 4) != 0)
                offset = OFFSET_W'($urandom_range(0, span_now - 1));
            else
                offset = OFFSET_W'($urandom);
            if (r < 2)
                send_word(REQ_NONE, 1'($urandom), 1'($urandom), POS_W'($urandom), $urandom,
                          OFFSET_W'($urandom));
            else if (r < 3)
                clear_store();
            else if (r < 25)
                read_back(offset);
            else if (r < 30)
                send_word(REQ_OP, 1'($urandom), 1'($urandom), POS_W'($urandom), $urandom,
                          OFFSET_W'($urandom));
            else
            begin
                first = (ops_left == 0);
                if (first)
                begin
                    ops_left = $urandom_range(1, 6);
                    strand   = ($urandom_range(0, 99) < 85) ? sel_now : ~sel_now;
                    if ($urandom_range(0, 4) != 0)
                        pos = POS_W'(ws_now + $urandom_range(0, span_now + 100) - 150);
                    else
                        pos = POS_W'($urandom);
                end
                r = $urandom_range(0, 99);
                if (r < 85)
                    len = 28'($urandom_range(0, 150));
                else if (r < 95)
                    len = 28'($urandom_range(0, 4000));
                else
                    len = 28'($urandom);
                code = ($urandom_range(0, 9) < 6) ? OP_MATCH : 4'($urandom_range(1, 15));
                send_op(strand, first, first ? pos : POS_W'($urandom), {len, code});
                ops_left--;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part, reset window [0, 4095], forward strand ---
        read_back(OFFSET_W'(0));                          // fresh store reads zero
        send_op(1'b0, 1'b1, POS_W'(10), op_word(5, OP_MATCH));  // 10..14
        send_op(1'b0, 1'b0, POS_W'($urandom), op_word(3, CIGAR_DEL));  // cursor to 18
        send_op(1'b0, 1'b0, POS_W'($urandom), op_word(2, OP_MATCH)); // 18, 19
        // other strand: dropped, cursor must not reload to 100
        send_op(1'b1, 1'b1, POS_W'(100), op_word(10, OP_MATCH));
        send_op(1'b0, 1'b0, POS_W'($urandom), op_word(1, OP_MATCH)); // 20
        read_back(OFFSET_W'(10));
        read_back(OFFSET_W'(17));
        read_back(OFFSET_W'(18));
        read_back(OFFSET_W'(20));
        read_back(OFFSET_W'(100));
        // runs off the window end, then a word with the cursor already past it
        send_op(1'b0, 1'b1, POS_W'(4090), op_word(100, OP_MATCH));
        send_op(1'b0, 1'b0, POS_W'($urandom), op_word(5, OP_MATCH));
        read_back(OFFSET_W'(4095));
        send_word(REQ_NONE, 1'b0, 1'b1, POS_W'(0), op_word(50, OP_MATCH), OFFSET_W'(0));
        send_op(1'b0, 1'b1, POS_W'(0), op_word(0, OP_MATCH));   // zero length
        send_op(1'b0, 1'b1, {POS_W{1'b1}}, {WORD_W{1'b1}});       // all-ones fields
        send_op(1'b0, 1'b1, POS_W'(4000), {28'hFFF_FFFF, OP_MATCH});  // longest op
        read_back(OFFSET_W'(4000));
        read_back({OFFSET_W{1'b1}});
        // clear zeroes counts but keeps the cursor
        send_op(1'b0, 1'b1, POS_W'(5), op_word(3, CIGAR_SOFT));
        clear_store();
        read_back({OFFSET_W{1'b1}});
        send_op(1'b0, 1'b0, POS_W'($urandom), op_word(4, OP_MATCH));  // 8..11
        read_back(OFFSET_W'(8));

        // --- random part, one window setting per phase ---
        feed_reads(100);

        // reverse strand, narrow window; receiver stalls while words keep coming
        set_window(POS_W'(1000), POS_W'(1500), 1'b1);
        hold_off_req = 1'b1;
        read_back(OFFSET_W'(0));
        read_back(OFFSET_W'(1));
        read_back(OFFSET_W'(2));
        feed_reads(100);

        // window ending at the top of the position range, no idling either side
        set_window(31'h7FFF_F000, 31'h7FFF_FFFF, 1'b0);
        no_gaps = 1'b1;
        feed_reads(100);

        // window end far beyond the store; sender pauses mid-phase until drained
        set_window(POS_W'(300), 31'h7FFF_FFFF, 1'b1);
        no_gaps = 1'b0;
        feed_reads(50);
        drain();
        feed_reads(50);

        // end before start: nothing may ever be counted
        set_window(POS_W'(5000), POS_W'(4000), 1'b0);
        feed_reads(50);

        // single-position windows at both ends of the range
        set_window(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        feed_reads(50);
        set_window(POS_W'(0), POS_W'(0), 1'b1);
        feed_reads(50);

        settle();
        if (errors == 0 && pending == 0)
            $display("** cigar_coverage_accumulator: PASSED **");
        else
            $display("** cigar_coverage_accumulator: FAILED **");
        $finish;
    end

endmodule
